@@ sv/mbpg_pkg.sv @@
package mbpg_pkg;

  // Pixels in one image word.
  localparam int WORD_BITS = 32;
  // Width of a gathered-pixel count (0 to WORD_BITS).
  localparam int CNT_W = 6;
  // Width of the pending fill (always below WORD_BITS).
  localparam int FILL_W = 5;
  // Width of the column counter and of the row width register.
  localparam int COL_W = 16;
  // Width of the running total.
  localparam int TOTAL_W = 32;
  // Row width after reset.
  localparam logic [COL_W-1:0] ROW_WIDTH_RESET = 16'd32;
  // Default depth of the queue between front and back.
  localparam int QUEUE_DEPTH_DEF = 2;

  // One compacted word travelling from front to back.
  typedef struct packed {
    logic [WORD_BITS-1:0] bits;
    logic [CNT_W-1:0]     cnt;
    logic                 eoi;
  } mbpg_item_t;

  // Parallel bit extract: packs the source bits selected by the map down to
  // bit 0. Groups of two are compacted, then pairs of groups are merged,
  // five levels in all, each level a set of independent small shifts.
  function automatic mbpg_item_t mbpg_compact(input logic [WORD_BITS-1:0] src,
                                              input logic [WORD_BITS-1:0] map);
    logic [WORD_BITS-1:0] b;
    logic [WORD_BITS-1:0] nb;
    logic [WORD_BITS-1:0] lo;
    logic [WORD_BITS-1:0] hi;
    logic [WORD_BITS-1:0] merged;
    logic [WORD_BITS-1:0] half_mask;
    logic [WORD_BITS-1:0] size_mask;
    logic [CNT_W-1:0]     c  [WORD_BITS];
    logic [CNT_W-1:0]     nc [WORD_BITS];
    mbpg_item_t           res;
    b = src & map;
    for (int i = 0; i < WORD_BITS; i++) begin
      c[i]  = {{(CNT_W-1){1'b0}}, map[i]};
      nc[i] = '0;
    end
    for (int s = 1; s <= 5; s++) begin
      nb        = '0;
      half_mask = (32'd1 << (1 << (s - 1))) - 32'd1;
      size_mask = (s == 5) ? '1 : ((32'd1 << (1 << s)) - 32'd1);
      for (int g = 0; g < (WORD_BITS >> s); g++) begin
        lo     = (b >> (g << s)) & half_mask;
        hi     = (b >> ((g << s) + (1 << (s - 1)))) & half_mask;
        merged = (lo | (hi << c[2*g])) & size_mask;
        nb     = nb | (merged << (g << s));
        nc[g]  = c[2*g] + c[2*g+1];
      end
      b = nb;
      for (int i = 0; i < WORD_BITS; i++) begin
        c[i] = nc[i];
      end
    end
    res.bits = b;
    res.cnt  = c[0];
    res.eoi  = 1'b0;
    return res;
  endfunction

endpackage

@@ sv/masked_binary_pixel_gather.sv @@
// Path: a word's results pass through the input stage, the queue and the
// output register, and wait in the queue behind any older words.
// Throughput: one word per cycle while the output is not stalled; a word that
// both fills a packed word and ends the image yields a full word and then a
// flush word through the single output register, and the next word waits for the flush.
// Reset (rst, synchronous) empties the pipeline, clears the packer, column
// and total, and sets the row width to 32.
module masked_binary_pixel_gather
  import mbpg_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [COL_W-1:0]     cfg_data,
  input  logic                 source_valid,
  output logic                 source_ready,
  input  logic [WORD_BITS-1:0] source_word,
  input  logic [WORD_BITS-1:0] map_word,
  input  logic                 end_of_image,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [WORD_BITS-1:0] packed_word,
  output logic [CNT_W-1:0]     bits_valid,
  output logic [TOTAL_W-1:0]   total_count,
  output logic                 is_last
);

  logic       front_valid;
  logic       front_ready;
  mbpg_item_t front_item;
  logic       back_valid;
  logic       back_ready;
  mbpg_item_t back_item;

  // Front: row masking and compaction.
  mbpg_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .source_valid (source_valid),
    .source_ready (source_ready),
    .source_word  (source_word),
    .map_word     (map_word),
    .end_of_image (end_of_image),
    .item_valid   (front_valid),
    .item_ready   (front_ready),
    .item         (front_item)
  );

  // Queue decoupling the front from the packer.
  mbpg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_item  (front_item),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_item   (back_item)
  );

  // Back: packer and output register.
  mbpg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (back_valid),
    .item_ready   (back_ready),
    .item         (back_item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .packed_word  (packed_word),
    .bits_valid   (bits_valid),
    .total_count  (total_count),
    .is_last      (is_last)
  );

`ifndef SYNTHESIS
  // Only the flush word of an image may be partly filled.
  a_full_unless_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && !is_last |-> bits_valid == CNT_W'(WORD_BITS))
    else $error("non-final word is not full");

  // Bits above the valid count are zero.
  a_unused_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && bits_valid < CNT_W'(WORD_BITS) |->
      (packed_word >> bits_valid) == '0)
    else $error("packed word has bits above its count");

  // A word that stalls on the output keeps its contents.
  a_hold_stalled: assert property (@(posedge clk) disable iff (rst)
    $past(result_valid && !result_ready) && !$past(rst) |->
      result_valid && $stable(packed_word) && $stable(total_count) && $stable(is_last))
    else $error("stalled result changed");
`endif

endmodule

@@ sv/mbpg_front.sv @@
module mbpg_front
  import mbpg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [COL_W-1:0]     cfg_data,
  input  logic                 source_valid,
  output logic                 source_ready,
  input  logic [WORD_BITS-1:0] source_word,
  input  logic [WORD_BITS-1:0] map_word,
  input  logic                 end_of_image,
  output logic                 item_valid,
  input  logic                 item_ready,
  output mbpg_item_t           item
);

  logic [COL_W-1:0]     row_width;
  logic [COL_W-1:0]     col;
  logic                 stage_valid;
  logic [WORD_BITS-1:0] stage_src;
  logic [WORD_BITS-1:0] stage_map;
  logic                 stage_eoi;
  logic [COL_W:0]       avail;
  logic                 row_ends;
  logic [CNT_W-1:0]     take;
  logic [WORD_BITS:0]   take_mask;
  logic                 accept;
  mbpg_item_t           packed_item;

  // Pixels left in the row, and how many of this word count.
  always_comb begin
    avail     = (col < row_width) ? ({1'b0, row_width} - {1'b0, col}) : '0;
    row_ends  = (avail <= (COL_W+1)'(WORD_BITS));
    take      = row_ends ? avail[CNT_W-1:0] : CNT_W'(WORD_BITS);
    take_mask = ((WORD_BITS+1)'(1) << take) - (WORD_BITS+1)'(1);
  end

  // The stage is free when empty or when its word moves on this cycle.
  assign source_ready = !stage_valid || item_ready;
  assign accept       = source_valid && source_ready;

  // Row width register and column counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_width <= ROW_WIDTH_RESET;
      col       <= '0;
    end else begin
      if (cfg_write) begin
        row_width <= cfg_data;
      end
      if (accept) begin
        if (end_of_image || row_ends) begin
          col <= '0;
        end else begin
          col <= col + COL_W'(WORD_BITS);
        end
      end
    end
  end

  // Input stage holding the masked word.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (source_ready) begin
      stage_valid <= source_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      stage_src <= source_word;
      stage_map <= map_word & take_mask[WORD_BITS-1:0];
      stage_eoi <= end_of_image;
    end
  end

  // Compaction of the staged word on its way into the queue.
  always_comb begin
    packed_item     = mbpg_compact(stage_src, stage_map);
    packed_item.eoi = stage_eoi;
  end

  assign item_valid = stage_valid;
  assign item       = packed_item;

endmodule

@@ sv/mbpg_queue.sv @@
module mbpg_queue
  import mbpg_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       push_valid,
  output logic       push_ready,
  input  mbpg_item_t push_item,
  output logic       pop_valid,
  input  logic       pop_ready,
  output mbpg_item_t pop_item
);

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  mbpg_item_t         entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               push;
  logic               pop;

  assign push_ready = (count != COUNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  // Pointers and fill count; pointers wrap at the depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

endmodule

@@ sv/mbpg_back.sv @@
module mbpg_back
  import mbpg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_ready,
  input  mbpg_item_t           item,
  output logic                 result_valid,
  input  logic                 result_ready,
  output logic [WORD_BITS-1:0] packed_word,
  output logic [CNT_W-1:0]     bits_valid,
  output logic [TOTAL_W-1:0]   total_count,
  output logic                 is_last
);

  logic [WORD_BITS-1:0]   pend;
  logic [FILL_W-1:0]      fill;
  logic [TOTAL_W-1:0]     total;
  logic                   flush_owed;
  logic [2*WORD_BITS-1:0] merged;
  logic [CNT_W-1:0]       new_fill;
  logic                   full;
  logic [WORD_BITS-1:0]   pend_next;
  logic [FILL_W-1:0]      fill_next;
  logic [TOTAL_W-1:0]     total_next;
  logic                   can_load;
  logic                   needs_out;

  // Merge the incoming pixels above the pending ones.
  always_comb begin
    merged     = {{WORD_BITS{1'b0}}, pend}
               | ({{WORD_BITS{1'b0}}, item.bits} << fill);
    new_fill   = CNT_W'(fill) + item.cnt;
    full       = new_fill[CNT_W-1];
    pend_next  = full ? merged[2*WORD_BITS-1:WORD_BITS] : merged[WORD_BITS-1:0];
    fill_next  = new_fill[FILL_W-1:0];
    total_next = total + TOTAL_W'(item.cnt);
  end

  assign can_load   = !result_valid || result_ready;
  assign needs_out  = full || item.eoi;
  assign item_ready = !flush_owed && (!needs_out || can_load);

  // Packer state and output register. A word that both fills the packer
  // and ends the image leaves a flush owed for the next free output slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend         <= '0;
      fill         <= '0;
      total        <= '0;
      flush_owed   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_ready) begin
        result_valid <= 1'b0;
      end
      if (flush_owed) begin
        if (can_load) begin
          result_valid <= 1'b1;
          packed_word  <= pend;
          bits_valid   <= CNT_W'(fill);
          total_count  <= total;
          is_last      <= 1'b1;
          pend         <= '0;
          fill         <= '0;
          total        <= '0;
          flush_owed   <= 1'b0;
        end
      end else if (item_valid && item_ready) begin
        if (full) begin
          result_valid <= 1'b1;
          packed_word  <= merged[WORD_BITS-1:0];
          bits_valid   <= CNT_W'(WORD_BITS);
          total_count  <= total_next;
          is_last      <= 1'b0;
          pend         <= pend_next;
          fill         <= fill_next;
          total        <= total_next;
          flush_owed   <= item.eoi;
        end else if (item.eoi) begin
          result_valid <= 1'b1;
          packed_word  <= pend_next;
          bits_valid   <= CNT_W'(fill_next);
          total_count  <= total_next;
          is_last      <= 1'b1;
          pend         <= '0;
          fill         <= '0;
          total        <= '0;
        end else begin
          pend  <= pend_next;
          fill  <= fill_next;
          total <= total_next;
        end
      end
    end
  end

endmodule

@@ tb/masked_binary_pixel_gather_checker.sv @@
`timescale 1ns / 1ps

module masked_binary_pixel_gather_checker
  import mbpg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [COL_W-1:0]     cfg_data,
  input  logic                 source_valid,
  input  logic                 source_ready,
  input  logic [WORD_BITS-1:0] source_word,
  input  logic [WORD_BITS-1:0] map_word,
  input  logic                 end_of_image,
  input  logic                 result_valid,
  input  logic                 result_ready,
  input  logic [WORD_BITS-1:0] packed_word,
  input  logic [CNT_W-1:0]     bits_valid,
  input  logic [TOTAL_W-1:0]   total_count,
  input  logic                 is_last,
  output int                   fail_count,
  output int                   expected_left
);

  // One packed word as the block should deliver it.
  typedef struct packed {
    logic [WORD_BITS-1:0] word;
    logic [CNT_W-1:0]     count;
    logic [TOTAL_W-1:0]   total;
    logic                 last;
  } gather_result_t;

  gather_result_t       expected_words[$];
  logic [COL_W-1:0]     row_width   = ROW_WIDTH_RESET;
  logic [WORD_BITS-1:0] pend_bits   = '0;
  int                   pend_fill   = 0;
  logic [COL_W-1:0]     column      = '0;
  logic [TOTAL_W-1:0]   image_total = '0;
  int                   failures    = 0;

  function automatic logic [WORD_BITS-1:0] low_ones(input int n);
    return (n == 0) ? '0 : ({WORD_BITS{1'b1}} >> (WORD_BITS - n));
  endfunction

  // Gathers one input word into the packer and queues the packed words it releases.
  task automatic predict_gather(input logic [WORD_BITS-1:0] src,
                                input logic [WORD_BITS-1:0] map,
                                input logic                 eoi);
    int                   avail;
    int                   take;
    int                   cnt;
    logic [WORD_BITS-1:0] sel;
    logic [WORD_BITS-1:0] g;
    logic [63:0]          merged;
    gather_result_t       r;
    // A word that reaches the row end keeps only the pixels left in the row.
    avail = (column < row_width) ? int'(row_width) - int'(column) : 0;
    if (avail <= WORD_BITS) begin
      take   = avail;
      column = '0;
    end else begin
      take   = WORD_BITS;
      column = column + COL_W'(WORD_BITS);
    end
    sel = map & low_ones(take);

    // Compact the selected source pixels down to bit 0.
    g   = '0;
    cnt = 0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (sel[i]) begin
        g[cnt] = src[i];
        cnt++;
      end
    end
    image_total = image_total + cnt;

    // Append to the pending bits; a full word goes out at once.
    if (cnt > 0) begin
      merged = {32'b0, pend_bits} | ({32'b0, g} << pend_fill);
      if (pend_fill + cnt >= WORD_BITS) begin
        r = '{merged[WORD_BITS-1:0], CNT_W'(WORD_BITS), image_total, 1'b0};
        expected_words.push_back(r);
        pend_fill = pend_fill + cnt - WORD_BITS;
        pend_bits = merged[63:32] & low_ones(pend_fill);
      end else begin
        pend_bits = merged[WORD_BITS-1:0];
        pend_fill = pend_fill + cnt;
      end
    end

    // The end of the image flushes whatever is pending, even nothing.
    if (eoi) begin
      r = '{pend_bits, CNT_W'(pend_fill), image_total, 1'b1};
      expected_words.push_back(r);
      pend_bits   = '0;
      pend_fill   = 0;
      column      = '0;
      image_total = '0;
    end
  endtask

  // Compare each delivered word with the oldest one expected, then predict new ones.
  always @(posedge clk) begin
    gather_result_t want;
    if (rst) begin
      expected_words.delete();
      row_width   = ROW_WIDTH_RESET;
      pend_bits   = '0;
      pend_fill   = 0;
      column      = '0;
      image_total = '0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_words.size() == 0) begin
          $error("packed word %h arrived with none expected", packed_word);
          failures++;
        end else begin
          want = expected_words.pop_front();
          if (packed_word !== want.word) begin
            $error("packed_word: expected %h, got %h", want.word, packed_word);
            failures++;
          end
          if (bits_valid !== want.count) begin
            $error("bits_valid: expected %0d, got %0d", want.count, bits_valid);
            failures++;
          end
          if (total_count !== want.total) begin
            $error("total_count: expected %0d, got %0d", want.total, total_count);
            failures++;
          end
          if (is_last !== want.last) begin
            $error("is_last: expected %b, got %b", want.last, is_last);
            failures++;
          end
        end
      end
      if (source_valid && source_ready) begin
        predict_gather(source_word, map_word, end_of_image);
      end
      if (cfg_write) begin
        row_width = cfg_data;
      end
    end
    fail_count    <= failures;
    expected_left <= expected_words.size();
  end

endmodule

@@ tb/masked_binary_pixel_gather_test.sv @@
`timescale 1ns / 1ps

module masked_binary_pixel_gather_test;
  import mbpg_pkg::*;

  localparam int PHASES       = 10;
  localparam int PHASE_WORDS  = 115;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 12;
  localparam int CYCLE_LIMIT  = 300000;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 cfg_write    = 1'b0;
  logic [COL_W-1:0]     cfg_data     = '0;
  logic                 source_valid = 1'b0;
  logic                 source_ready;
  logic [WORD_BITS-1:0] source_word  = '0;
  logic [WORD_BITS-1:0] map_word     = '0;
  logic                 end_of_image = 1'b0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic [WORD_BITS-1:0] packed_word;
  logic [CNT_W-1:0]     bits_valid;
  logic [TOTAL_W-1:0]   total_count;
  logic                 is_last;
  int                   fail_count;
  int                   expected_left;

  int sender_idle_pct = 0;
  int sink_stall_pct  = 0;
  int hold_token      = 0;
  int hold_seen       = 0;
  int hold_left       = 0;
  int cycle_count     = 0;

  masked_binary_pixel_gather i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .source_valid (source_valid),
    .source_ready (source_ready),
    .source_word  (source_word),
    .map_word     (map_word),
    .end_of_image (end_of_image),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .packed_word  (packed_word),
    .bits_valid   (bits_valid),
    .total_count  (total_count),
    .is_last      (is_last)
  );

  masked_binary_pixel_gather_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .source_valid  (source_valid),
    .source_ready  (source_ready),
    .source_word   (source_word),
    .map_word      (map_word),
    .end_of_image  (end_of_image),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .packed_word   (packed_word),
    .bits_valid    (bits_valid),
    .total_count   (total_count),
    .is_last       (is_last),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // The receiver stalls at random, or holds off for a long stretch on request.
  always @(posedge clk) begin
    if (hold_seen != hold_token) begin
      hold_seen    <= hold_token;
      hold_left    <= HOLD_CYCLES;
      result_ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  // Give up if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Offers one input word after a random gap and waits until it is taken.
  task automatic send_word(input logic [WORD_BITS-1:0] src,
                           input logic [WORD_BITS-1:0] map,
                           input logic                 eoi);
    while ($urandom_range(99) < sender_idle_pct) begin
      source_valid <= 1'b0;
      @(posedge clk);
    end
    source_valid <= 1'b1;
    source_word  <= src;
    map_word     <= map;
    end_of_image <= eoi;
    do @(posedge clk); while (!source_ready);
  endtask

  // Stops offering words and waits until every expected word has come out.
  task automatic drain_pipeline();
    source_valid <= 1'b0;
    do @(posedge clk); while (expected_left != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_row_width(input logic [COL_W-1:0] w);
    drain_pipeline();
    cfg_write <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  initial begin
    logic [WORD_BITS-1:0] map;
    logic [COL_W-1:0]     width;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed words at the reset row width of 32.
    send_word(32'h0000_0000, 32'h0000_0000, 1'b1);   // flush with nothing pending
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);   // one full word
    send_word(32'hAAAA_AAAA, 32'hFFFF_0000, 1'b0);   // half a word pending
    send_word(32'h1234_5678, 32'hFFFF_FFFF, 1'b1);   // full word and flush together
    send_word(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_word(32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
    send_word(32'hFFFF_FFFF, 32'h8000_0001, 1'b1);

    // A row of 40 pixels: the second word keeps only 8 of them.
    write_row_width(16'd40);
    send_word(32'hDEAD_BEEF, 32'hFFFF_FFFF, 1'b0);
    send_word(32'hCAFE_F00D, 32'hFFFF_FFFF, 1'b0);
    send_word(32'h0F0F_0F0F, 32'hFFFF_FFFF, 1'b1);

    // Shrinking the row under the current column leaves no pixel in the row.
    write_row_width(16'd100);
    send_word(32'h8765_4321, 32'hFFFF_FFFF, 1'b0);
    send_word(32'h1357_9BDF, 32'hFFFF_FFFF, 1'b0);
    send_word(32'h2468_ACE0, 32'hFFFF_FFFF, 1'b0);
    write_row_width(16'd40);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    // A zero row width gathers nothing.
    write_row_width(16'd0);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);

    // One pixel per row.
    write_row_width(16'd1);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_word(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_word(32'hFFFF_FFFE, 32'hFFFF_FFFF, 1'b1);

    // Random phases, each with its own row width and idling pattern.
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0:       width = 16'd32;
        1:       width = 16'd1;
        2:       width = 16'd65535;
        3:       width = 16'd0;
        4:       width = 16'd40;
        5:       width = 16'd31;
        6:       width = 16'd33;
        7:       width = 16'd100;
        8:       width = 16'd7;
        default: width = COL_W'($urandom_range(2, 200));
      endcase
      write_row_width(width);
      case (phase % 4)
        0: begin
          sender_idle_pct = 0;
          sink_stall_pct <= 0;
        end
        1: begin
          sender_idle_pct = 62;
          sink_stall_pct <= 0;
        end
        2: begin
          sender_idle_pct = 0;
          sink_stall_pct <= 62;
        end
        default: begin
          sender_idle_pct = 7;
          sink_stall_pct <= 7;
        end
      endcase
      // Hold the receiver off while words keep coming, so the block backs up.
      if (phase == 4) begin
        hold_token <= hold_token + 1;
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        case ($urandom_range(5))
          0:       map = '1;
          1:       map = '0;
          2:       map = $urandom() & $urandom();
          3:       map = $urandom() | $urandom();
          default: map = $urandom();
        endcase
        send_word($urandom(), map, ($urandom_range(11) == 0) || (phase == PHASES - 1
                  && n == PHASE_WORDS - 1));
      end
    end

    drain_pipeline();
    if (fail_count == 0 && expected_left == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
